### src/qsf_pkg.sv
// Package with the shared types and constants of the 16-node quad shape function unit.
package qsf_pkg;

  // Fields of one input transfer: a local coordinate pair.
  typedef struct packed {
    logic signed [15:0] xi;
    logic signed [15:0] eta;
  } qsf_in_t;

  // Fields of one result transfer: one node's shape function value.
  typedef struct packed {
    logic [3:0]         node_index;
    logic signed [15:0] shape_value;
    logic               last_node;
  } qsf_out_t;

  // Basis selection for one node: xi basis p, eta basis q.
  typedef struct packed {
    logic [1:0] p;
    logic [1:0] q;
  } qsf_pair_t;

  localparam int unsigned NUM_BASES = 4;
  localparam logic [3:0]  LAST_NODE = 4'd15;

  // Node numbering of the 16-node quadrilateral: corners, edge nodes, then interior.
  function automatic qsf_pair_t node_pair(input logic [3:0] k);
    qsf_pair_t r;
    unique case (k)
      4'd0:    r = '{p: 2'd0, q: 2'd0};
      4'd1:    r = '{p: 2'd3, q: 2'd0};
      4'd2:    r = '{p: 2'd3, q: 2'd3};
      4'd3:    r = '{p: 2'd0, q: 2'd3};
      4'd4:    r = '{p: 2'd1, q: 2'd0};
      4'd5:    r = '{p: 2'd2, q: 2'd0};
      4'd6:    r = '{p: 2'd3, q: 2'd1};
      4'd7:    r = '{p: 2'd3, q: 2'd2};
      4'd8:    r = '{p: 2'd2, q: 2'd3};
      4'd9:    r = '{p: 2'd1, q: 2'd3};
      4'd10:   r = '{p: 2'd0, q: 2'd2};
      4'd11:   r = '{p: 2'd0, q: 2'd1};
      4'd12:   r = '{p: 2'd1, q: 2'd1};
      4'd13:   r = '{p: 2'd2, q: 2'd1};
      4'd14:   r = '{p: 2'd2, q: 2'd2};
      default: r = '{p: 2'd1, q: 2'd2};
    endcase
    return r;
  endfunction

endpackage

### src/qsf_basis.sv
// Four-stage pipeline that clamps one coordinate and evaluates its four cubic Lagrange bases.
module qsf_basis #(
  parameter int FRAC_BITS = 14
) (
  input  logic                         clk,
  input  logic [3:0]                   en,
  input  logic signed [15:0]           x_in,
  output logic signed [FRAC_BITS+1:0]  basis_out [qsf_pkg::NUM_BASES]
);

  localparam int BW   = FRAC_BITS + 2;
  localparam int SUMW = FRAC_BITS + 8;

  localparam logic signed [31:0] ONE32     = 32'(1) << FRAC_BITS;
  localparam logic signed [31:0] NEG_ONE32 = -ONE32;
  localparam logic signed [31:0] HALF32    = 32'(1) << (FRAC_BITS - 1);
  localparam logic signed [32:0] HALF33    = 33'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUMW-1:0] ONE_S  = SUMW'(1) << FRAC_BITS;
  localparam logic signed [SUMW-1:0] HALF_S = SUMW'(8);

  logic signed [15:0]     x0_r, x1_r, x2_r;
  logic signed [16:0]     t2_1_r, t2_2_r, t3_2_r;
  logic signed [BW-1:0]   basis_r [qsf_pkg::NUM_BASES];

  logic signed [31:0]     x_ext, x_clamp, xx, xx_rnd;
  logic signed [32:0]     t2x, t2x_rnd;
  logic signed [SUMW-1:0] t3_s, t2_s, x_s;
  logic signed [SUMW-1:0] sum [qsf_pkg::NUM_BASES];
  logic signed [SUMW-1:0] sum_rnd [qsf_pkg::NUM_BASES];

  // Clamp to [-1, +1]; with 15 or more fraction bits no 16-bit input goes past the bounds.
  always_comb begin
    x_ext = 32'(x_in);
    if (x_ext > ONE32) begin
      x_clamp = ONE32;
    end else if (x_ext < NEG_ONE32) begin
      x_clamp = NEG_ONE32;
    end else begin
      x_clamp = x_ext;
    end
  end

  // Round half away from zero: add half, less one for negative values, then shift.
  // The sign correction is kept signed so that the shifts stay arithmetic.
  always_comb begin
    xx      = x0_r * x0_r;
    xx_rnd  = (xx + HALF32 - $signed(32'(xx[31]))) >>> FRAC_BITS;
    t2x     = t2_1_r * x1_r;
    t2x_rnd = (t2x + HALF33 - $signed(33'(t2x[32]))) >>> FRAC_BITS;
  end

  // Constant coefficients 9 and 27 are built from shifts and adds.
  always_comb begin
    t3_s = SUMW'(t3_2_r);
    t2_s = SUMW'(t2_2_r);
    x_s  = SUMW'(x2_r);
    sum[0] = -((t3_s <<< 3) + t3_s) + ((t2_s <<< 3) + t2_s) + x_s - ONE_S;
    sum[1] = ((t3_s <<< 4) + (t3_s <<< 3) + (t3_s <<< 1) + t3_s)
           - ((t2_s <<< 3) + t2_s)
           - ((x_s <<< 4) + (x_s <<< 3) + (x_s <<< 1) + x_s)
           + ((ONE_S <<< 3) + ONE_S);
    sum[2] = -((t3_s <<< 4) + (t3_s <<< 3) + (t3_s <<< 1) + t3_s)
           - ((t2_s <<< 3) + t2_s)
           + ((x_s <<< 4) + (x_s <<< 3) + (x_s <<< 1) + x_s)
           + ((ONE_S <<< 3) + ONE_S);
    sum[3] = ((t3_s <<< 3) + t3_s) + ((t2_s <<< 3) + t2_s) - x_s - ONE_S;
    for (int i = 0; i < qsf_pkg::NUM_BASES; i++) begin
      sum_rnd[i] = (sum[i] + HALF_S - $signed(SUMW'(sum[i][SUMW-1]))) >>> 4;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x0_r <= x_clamp[15:0];
    end
    if (en[1]) begin
      x1_r   <= x0_r;
      t2_1_r <= xx_rnd[16:0];
    end
    if (en[2]) begin
      x2_r   <= x1_r;
      t2_2_r <= t2_1_r;
      t3_2_r <= t2x_rnd[16:0];
    end
    if (en[3]) begin
      for (int i = 0; i < qsf_pkg::NUM_BASES; i++) begin
        basis_r[i] <= sum_rnd[i][BW-1:0];
      end
    end
  end

  assign basis_out = basis_r;

endmodule

### src/quad16_shape_function_eval_unit.sv
// Top level of the 16-node bicubic quadrilateral shape function evaluation unit.
//
//   Channel   Ports                        Moves
//   input     start, busy, in_data         one (xi, eta) pair per transfer
//   result    out_strobe, out_data         one node value per transfer, 16 per input
//
// An input transfer takes place at a rising edge with start high and busy low. The
// first result of an input passes the four basis stages, node sequencer, product
// stage and output register; all 16 follow on consecutive cycles. One result port
// sets the sustained rate at one input per 16 results. Reset is synchronous and active
// low; it clears only the valid bits and node sequencer. The receiver cannot stall,
// so busy rises only when the basis pipeline has backed up behind the node sequencer.
module quad16_shape_function_eval_unit #(
  parameter int FRAC_BITS = 14
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  qsf_pkg::qsf_in_t  in_data,
  output logic              out_strobe,
  output qsf_pkg::qsf_out_t out_data
);

  localparam int BW = FRAC_BITS + 2;       // basis value width
  localparam int PW = 2 * BW;              // product width
  localparam int RW = (FRAC_BITS + 4 > 17) ? FRAC_BITS + 4 : 17;

  localparam logic signed [PW-1:0] HALF_P = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [RW-1:0] SAT_HI = RW'(32767);
  localparam logic signed [RW-1:0] SAT_LO = ~RW'(32767);

  // Basis pipeline control: one valid bit per stage, shared by both coordinates.
  logic [3:0]           v_r;
  logic [3:0]           en;
  logic                 accept;
  logic signed [BW-1:0] a_basis [qsf_pkg::NUM_BASES];
  logic signed [BW-1:0] b_basis [qsf_pkg::NUM_BASES];

  // Node sequencer: holds one item's bases while its sixteen products are formed.
  logic                 active_r;
  logic [3:0]           cnt_r;
  logic                 ld_rdy;
  logic                 ld;
  logic signed [BW-1:0] a_r [qsf_pkg::NUM_BASES];
  logic signed [BW-1:0] b_r [qsf_pkg::NUM_BASES];
  qsf_pkg::qsf_pair_t   pair;

  // Product stage and output register.
  logic                 e1_v_r;
  logic [3:0]           e1_node_r;
  logic signed [PW-1:0] e1_prod_r;
  logic signed [PW-1:0] prod_adj;
  logic signed [PW-1:0] prod_sh;
  logic signed [RW-1:0] rnd;
  logic signed [15:0]   sat;
  logic                 out_strobe_r;
  qsf_pkg::qsf_out_t    out_data_r;

  // The sequencer can take new bases when idle or while it issues its final node.
  assign ld_rdy = !active_r || (cnt_r == qsf_pkg::LAST_NODE);
  assign ld     = v_r[3] && ld_rdy;

  // A stage loads when it is empty or its contents move on in the same cycle.
  assign en[3]  = !v_r[3] || ld_rdy;
  assign en[2]  = !v_r[2] || en[3];
  assign en[1]  = !v_r[1] || en[2];
  assign en[0]  = !v_r[0] || en[1];
  assign busy   = !en[0];
  assign accept = start && en[0];

  qsf_basis #(.FRAC_BITS(FRAC_BITS)) u_basis_xi (
    .clk       (clk),
    .en        (en),
    .x_in      (in_data.xi),
    .basis_out (a_basis)
  );

  qsf_basis #(.FRAC_BITS(FRAC_BITS)) u_basis_eta (
    .clk       (clk),
    .en        (en),
    .x_in      (in_data.eta),
    .basis_out (b_basis)
  );

  assign pair = qsf_pkg::node_pair(cnt_r);

  // Final rounding of the product, half away from zero, then saturation to 16 bits.
  always_comb begin
    prod_adj = e1_prod_r + HALF_P - PW'(e1_prod_r[PW-1]);
    prod_sh  = prod_adj >>> FRAC_BITS;
    rnd      = prod_sh[RW-1:0];
    if (rnd > SAT_HI) begin
      sat = 16'sh7FFF;
    end else if (rnd < SAT_LO) begin
      sat = -16'sh8000;
    end else begin
      sat = rnd[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r          <= '0;
      active_r     <= 1'b0;
      cnt_r        <= '0;
      e1_v_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (en[0]) v_r[0] <= accept;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
      if (ld) begin
        active_r <= 1'b1;
        cnt_r    <= '0;
      end else if (active_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == qsf_pkg::LAST_NODE) begin
          active_r <= 1'b0;
        end
      end
      e1_v_r       <= active_r;
      out_strobe_r <= e1_v_r;
    end
  end

  // Payload registers carry no reset; the valid bits above qualify them.
  always_ff @(posedge clk) begin
    if (ld) begin
      a_r <= a_basis;
      b_r <= b_basis;
    end
    e1_node_r <= cnt_r;
    e1_prod_r <= a_r[pair.p] * b_r[pair.q];
    out_data_r.node_index  <= e1_node_r;
    out_data_r.shape_value <= sat;
    out_data_r.last_node   <= (e1_node_r == qsf_pkg::LAST_NODE);
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

### bench/qsf_node_value_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the 16 node values per coordinate pair and compares the results.
module qsf_node_value_checker #(
  parameter int FRAC_BITS = 14
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  qsf_pkg::qsf_in_t  in_data,
  input  logic              out_strobe,
  input  qsf_pkg::qsf_out_t out_data,
  output int                mismatch_count,
  output int                node_values_owed
);

  // Basis selectors per node, two bits per node, node 0 in the low bits.
  localparam logic [31:0] XI_SEL  = {2'd1, 2'd2, 2'd2, 2'd1, 2'd0, 2'd0, 2'd1, 2'd2,
                                     2'd3, 2'd3, 2'd2, 2'd1, 2'd0, 2'd3, 2'd3, 2'd0};
  localparam logic [31:0] ETA_SEL = {2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd2, 2'd3, 2'd3,
                                     2'd2, 2'd1, 2'd0, 2'd0, 2'd3, 2'd3, 2'd0, 2'd0};

  qsf_pkg::qsf_out_t node_values_due[$];

  initial begin
    mismatch_count   = 0;
    node_values_owed = 0;
  end

  // Divides by 2^s and rounds to nearest, ties away from zero.
  function automatic longint round_shift_away(input longint v, input int s);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (longint'(1) <<< (s - 1))) >>> s;
    return (v < 0) ? -mag : mag;
  endfunction

  // One cubic Lagrange basis of a clamped coordinate, in fixed point.
  function automatic longint cubic_basis(input logic signed [15:0] raw, input logic [1:0] idx);
    longint one;
    longint x;
    longint x2;
    longint x3;
    longint sum;
    one = longint'(1) <<< FRAC_BITS;
    x   = longint'(raw);
    if (x > one) x = one;
    if (x < -one) x = -one;
    x2 = round_shift_away(x * x, FRAC_BITS);
    x3 = round_shift_away(x2 * x, FRAC_BITS);
    case (idx)
      2'd0:    sum =  -9 * x3 + 9 * x2 +      x -     one;
      2'd1:    sum =  27 * x3 - 9 * x2 - 27 * x + 9 * one;
      2'd2:    sum = -27 * x3 - 9 * x2 + 27 * x + 9 * one;
      default: sum =   9 * x3 + 9 * x2 -      x -     one;
    endcase
    return round_shift_away(sum, 4);
  endfunction

  task automatic predict_node_values(input qsf_pkg::qsf_in_t coord);
    qsf_pkg::qsf_out_t nv;
    longint            prod;
    for (int k = 0; k < 16; k++) begin
      prod = round_shift_away(cubic_basis(coord.xi, XI_SEL[2*k +: 2]) *
                              cubic_basis(coord.eta, ETA_SEL[2*k +: 2]), FRAC_BITS);
      if (prod > 32767) prod = 32767;
      if (prod < -32768) prod = -32768;
      nv.node_index  = 4'(k);
      nv.shape_value = prod[15:0];
      nv.last_node   = (4'(k) == qsf_pkg::LAST_NODE);
      node_values_due.push_back(nv);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] node value mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    qsf_pkg::qsf_out_t want;
    if (!rst_n) begin
      node_values_due.delete();
    end else begin
      // Results are checked before new predictions join, so a result in the transfer's own cycle fails.
      if (out_strobe) begin
        if (node_values_due.size() == 0) begin
          report_mismatch("unexpected result, node", out_data.node_index, -1);
        end else begin
          want = node_values_due.pop_front();
          if (out_data.node_index !== want.node_index)
            report_mismatch("node_index", out_data.node_index, want.node_index);
          if (out_data.shape_value !== want.shape_value)
            report_mismatch("shape_value", out_data.shape_value, want.shape_value);
          if (out_data.last_node !== want.last_node)
            report_mismatch("last_node", out_data.last_node, want.last_node);
        end
      end
      if (start && !busy) predict_node_values(in_data);
    end
    node_values_owed = node_values_due.size();
  end

endmodule

### bench/quad16_shape_function_eval_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top: coordinate stimulus, checker hookup and the final verdict.
module quad16_shape_function_eval_unit_tb;

  localparam int FRAC_BITS   = 14;
  localparam int IDLE_PCT    = 31;
  localparam int RANDOM_PAIRS = 141;
  // Far above the slowest legal run: under 200 transfers of 16 results plus gaps.
  localparam int CYCLE_LIMIT = 200000;
  // Results pass the basis pipeline, sequencer and output stages, then sixteen in a row.
  localparam int DRAIN_CYCLES = 40;

  logic              clk;
  logic              rst_n   = 1'b0;
  logic              start   = 1'b0;
  qsf_pkg::qsf_in_t  in_data = '0;
  logic              busy;
  logic              out_strobe;
  qsf_pkg::qsf_out_t out_data;
  int                mismatch_count;
  int                node_values_owed;
  int                cycle_count = 0;
  logic              idling_on = 1'b1;

  quad16_shape_function_eval_unit #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  // The checker sees both channels exactly as the block does and keeps its own count.
  qsf_node_value_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_data         (in_data),
    .out_strobe      (out_strobe),
    .out_data        (out_data),
    .mismatch_count  (mismatch_count),
    .node_values_owed(node_values_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Presents one coordinate pair and returns right after the edge that took the transfer.
  // Busy is sampled on the falling edge, where it is settled, so the decision does not
  // depend on the order of events at the rising edge. Random idle cycles come first.
  task automatic send_coord_pair(input logic signed [15:0] xi, input logic signed [15:0] eta);
    logic taken;
    while (idling_on && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= '{xi: xi, eta: eta};
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  // Most coordinates lie inside the element, some sit near the node lines, and the rest
  // roam the whole 16-bit range so that clamping and every bit get exercised.
  function automatic logic signed [15:0] pick_coord();
    int sel;
    int nodes [4];
    nodes = '{-16384, -5461, 5461, 16384};
    sel = $urandom_range(99);
    if (sel < 65) return 16'($signed($urandom_range(32768)) - 16384);
    if (sel < 82) return 16'(nodes[$urandom_range(3)] + $signed($urandom_range(6)) - 3);
    return 16'($urandom);
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: element corners, the interior node lines at +-1/3, the center,
    // values just past the element edge and the 16-bit extremes, which must clamp.
    send_coord_pair(16'sd0, 16'sd0);
    send_coord_pair(16'sd16384, 16'sd16384);
    send_coord_pair(-16'sd16384, -16'sd16384);
    send_coord_pair(16'sd16384, -16'sd16384);
    send_coord_pair(-16'sd16384, 16'sd16384);
    send_coord_pair(16'sd5461, 16'sd5461);
    send_coord_pair(-16'sd5461, -16'sd5461);
    send_coord_pair(16'sd5462, -16'sd5462);
    send_coord_pair(16'sd16383, -16'sd16383);
    send_coord_pair(16'sd16385, -16'sd16385);
    send_coord_pair(16'sd32767, -16'sd32768);
    send_coord_pair(-16'sd32768, 16'sd32767);
    send_coord_pair(16'sd20000, 16'sd0);
    send_coord_pair(16'sd0, -16'sd20000);
    send_coord_pair(16'sd1, -16'sd1);
    send_coord_pair(16'sd8192, -16'sd8192);
    send_coord_pair(16'sh5555, 16'shAAAA);
    send_coord_pair(16'shAAAA, 16'sh5555);
    send_coord_pair(16'sh00FF, 16'shFF00);

    // Random part, with a stretch of back-to-back transfers in the middle to keep the
    // basis pipeline pressed against the node sequencer.
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      idling_on = !(n >= 60 && n < 100);
      send_coord_pair(pick_coord(), pick_coord());
    end
    start <= 1'b0;

    do @(negedge clk); while (node_values_owed != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
